// ----- hw/rtl/rrq_pkg.sv -----
// Shared types and constants of the round-robin run queue unit.
package rrq_pkg;

  // Widths of the stream fields, fixed by the command and result formats.
  localparam int TASK_ID_W    = 7;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int TASK_COUNT_W = 8;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_FIELDS_W = STATUS_W + 2 * TASK_ID_W + 1 + TASK_COUNT_W;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE   = 2'd0,
    CMD_UNSCHEDULE = 2'd1,
    CMD_ENQUEUE    = 2'd2,
    CMD_DEQUEUE    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FULL       = 2'd1,
    STATUS_FREE       = 2'd2,
    STATUS_MEMBERSHIP = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_DECODE,
    CS_SCAN,
    CS_FLAGS,
    CS_LINK_RD,
    CS_LINK_GOT,
    CS_WALK,
    CS_APPEND,
    CS_FINISH,
    CS_DONE
  } ctrl_state_e;

  // Per-slot flags held in the flag memory.
  typedef struct packed {
    logic used;
    logic queued;
  } slot_flags_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear;
    logic    load;
    logic    scan;
    logic    latch_flags;
    logic    latch_succ;
    logic    walk_start;
    logic    walk_step;
    logic    take_prev;
    logic    append;
    logic    finish;
    logic    set_status;
    status_e status_code;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic id_valid;
    logic used;
    logic queued;
    logic is_head;
    logic head_is_tail;
    logic scan_hit;
    logic walk_hit;
    logic walk_end;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/rrq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rrq_ctrl.sv -----
// Controller state machine that sequences each command through the datapath.
module rrq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrq_pkg::dp_status_t status_i,
  output rrq_pkg::dp_cmd_t    cmd_o
);

  import rrq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      CS_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_DECODE;
        end
      end
      CS_DECODE: begin
        if (status_i.cmd == CMD_SCHEDULE) begin
          if (status_i.full) begin
            cmd_o.set_status  = 1'b1;
            cmd_o.status_code = STATUS_FULL;
            state_d           = CS_DONE;
          end else begin
            state_d = CS_SCAN;
          end
        end else if (!status_i.id_valid) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = STATUS_FREE;
          state_d           = CS_DONE;
        end else begin
          state_d = CS_FLAGS;
        end
      end
      CS_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_hit) begin
          state_d = CS_APPEND;
        end
      end
      CS_FLAGS: begin
        cmd_o.latch_flags = 1'b1;
        if (!status_i.used) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = STATUS_FREE;
          state_d           = CS_DONE;
        end else begin
          unique case (status_i.cmd)
            CMD_UNSCHEDULE: begin
              state_d = status_i.queued ? CS_LINK_RD : CS_FINISH;
            end
            CMD_ENQUEUE: begin
              if (status_i.queued) begin
                cmd_o.set_status  = 1'b1;
                cmd_o.status_code = STATUS_MEMBERSHIP;
                state_d           = CS_DONE;
              end else begin
                state_d = CS_APPEND;
              end
            end
            CMD_DEQUEUE: begin
              if (!status_i.queued) begin
                cmd_o.set_status  = 1'b1;
                cmd_o.status_code = STATUS_MEMBERSHIP;
                state_d           = CS_DONE;
              end else begin
                state_d = CS_LINK_RD;
              end
            end
            default: begin
              state_d = CS_DONE;
            end
          endcase
        end
      end
      CS_LINK_RD: begin
        state_d = CS_LINK_GOT;
      end
      CS_LINK_GOT: begin
        cmd_o.latch_succ = 1'b1;
        if (status_i.is_head || status_i.head_is_tail) begin
          state_d = CS_FINISH;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = CS_WALK;
        end
      end
      CS_WALK: begin
        if (status_i.walk_hit) begin
          cmd_o.take_prev = 1'b1;
          state_d         = CS_FINISH;
        end else if (status_i.walk_end) begin
          state_d = CS_FINISH;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      CS_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = CS_DONE;
      end
      CS_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = CS_DONE;
      end
      CS_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/rrq_dp.sv -----
// Datapath: slot flag and link memories, queue registers and result register.
module rrq_dp #(
  parameter int SLOT_COUNT = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [rrq_pkg::CMD_W-1:0]            in_cmd_i,
  input  logic [rrq_pkg::TASK_ID_W-1:0]        in_task_id_i,
  input  rrq_pkg::dp_cmd_t                     cmd_i,
  output rrq_pkg::dp_status_t                  status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rrq_pkg::OUT_TDATA_W-1:0]      out_data_o
);

  import rrq_pkg::*;

  localparam int ID_W  = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // Command registers.
  cmd_e            cmd_q;
  logic [ID_W-1:0] id_q;
  logic            id_valid_q;
  logic            queued_q;

  // Queue and scheduler state.
  logic [ID_W-1:0]  head_q, tail_q, cur_q;
  logic             empty_q, idle_q;
  logic [CNT_W-1:0] count_q;

  // Work registers of the free-slot scan and the predecessor walk.
  logic [ID_W-1:0] clr_ptr_q, scan_q, chk_q, p_q, prev_q, succ_q;
  logic            chk_vld_q, has_prev_q, has_succ_q;

  // Result register.
  status_e               status_q;
  logic [TASK_ID_W-1:0]  assigned_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [TASK_ID_W-1:0]  out_assigned_q, out_run_q;
  logic                  out_idle_q;
  logic [TASK_COUNT_W-1:0] out_count_q;

  // Memory ports.
  logic            flag_we, link_we;
  logic [ID_W-1:0] flag_waddr, flag_raddr, link_waddr, link_raddr;
  slot_flags_t     flag_wdata, flag_rdata;
  logic [ID_W-1:0] link_wdata, link_rdata;

  logic [31:0]     raw_id;
  logic            in_id_valid;
  logic            is_tail;
  logic            scan_hit;

  assign raw_id      = 32'(in_task_id_i);
  assign in_id_valid = raw_id < 32'(SLOT_COUNT);
  assign is_tail     = (id_q == tail_q);
  assign scan_hit    = cmd_i.scan && chk_vld_q && !flag_rdata.used;

  rrq_ram #(
    .WIDTH($bits(slot_flags_t)),
    .DEPTH(SLOT_COUNT)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(flag_waddr),
    .wdata_i(flag_wdata),
    .raddr_i(flag_raddr),
    .rdata_o(flag_rdata)
  );

  rrq_ram #(
    .WIDTH(ID_W),
    .DEPTH(SLOT_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  // Memory port selection.
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = id_q;
    flag_wdata = '0;
    if (cmd_i.clear) begin
      flag_we    = 1'b1;
      flag_waddr = clr_ptr_q;
    end else if (cmd_i.append) begin
      flag_we    = 1'b1;
      flag_wdata = '{used: 1'b1, queued: 1'b1};
    end else if (cmd_i.finish) begin
      flag_we    = 1'b1;
      flag_wdata = '{used: (cmd_q != CMD_UNSCHEDULE), queued: 1'b0};
    end
    flag_raddr = cmd_i.scan ? scan_q : id_q;

    link_we    = 1'b0;
    link_waddr = tail_q;
    link_wdata = id_q;
    if (cmd_i.append && !empty_q) begin
      link_we = 1'b1;
    end else if (cmd_i.finish && queued_q && has_prev_q && has_succ_q) begin
      link_we    = 1'b1;
      link_waddr = prev_q;
      link_wdata = succ_q;
    end

    if (cmd_i.walk_start) begin
      link_raddr = head_q;
    end else if (cmd_i.walk_step) begin
      link_raddr = link_rdata;
    end else begin
      link_raddr = id_q;
    end
  end

  // Control state: queue pointers, running task, count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      empty_q     <= 1'b1;
      cur_q       <= '0;
      idle_q      <= 1'b1;
      count_q     <= '0;
      clr_ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
      end
      if (cmd_i.append) begin
        if (empty_q) begin
          head_q  <= id_q;
          empty_q <= 1'b0;
        end
        tail_q <= id_q;
        if (idle_q) begin
          cur_q  <= id_q;
          idle_q <= 1'b0;
        end
        if (cmd_q == CMD_SCHEDULE) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (queued_q) begin
          if (id_q == head_q) begin
            if (is_tail) begin
              empty_q <= 1'b1;
            end else begin
              head_q <= succ_q;
            end
          end
          if (is_tail && has_prev_q) begin
            tail_q <= prev_q;
          end
          if (!idle_q && (cur_q == id_q)) begin
            if (has_succ_q) begin
              cur_q <= succ_q;
            end else begin
              cur_q  <= '0;
              idle_q <= 1'b1;
            end
          end
        end
        if ((cmd_q == CMD_UNSCHEDULE) && (count_q != '0)) begin
          count_q <= count_q - 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-command work registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q      <= cmd_e'(in_cmd_i);
      id_q       <= ID_W'(raw_id);
      id_valid_q <= in_id_valid;
      status_q   <= STATUS_OK;
      assigned_q <= '0;
      scan_q     <= '0;
      chk_vld_q  <= 1'b0;
      has_prev_q <= 1'b0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.scan) begin
      chk_q     <= scan_q;
      chk_vld_q <= 1'b1;
      if (scan_q != ID_W'(SLOT_COUNT - 1)) begin
        scan_q <= scan_q + 1'b1;
      end
      if (scan_hit) begin
        id_q <= chk_q;
      end
    end
    if (cmd_i.latch_flags) begin
      queued_q <= flag_rdata.queued;
    end
    if (cmd_i.latch_succ) begin
      succ_q     <= link_rdata;
      has_succ_q <= !is_tail;
    end
    if (cmd_i.walk_start) begin
      p_q <= head_q;
    end
    if (cmd_i.walk_step) begin
      p_q <= link_rdata;
    end
    if (cmd_i.take_prev) begin
      prev_q     <= p_q;
      has_prev_q <= 1'b1;
    end
    if (cmd_i.append && (cmd_q == CMD_SCHEDULE)) begin
      assigned_q <= TASK_ID_W'(id_q);
    end
    if (cmd_i.out_load) begin
      out_status_q   <= status_q;
      out_assigned_q <= assigned_q;
      out_run_q      <= idle_q ? '0 : TASK_ID_W'(cur_q);
      out_idle_q     <= idle_q;
      out_count_q    <= TASK_COUNT_W'(count_q);
    end
  end

  always_comb begin
    status_o              = '0;
    status_o.cmd          = cmd_q;
    status_o.full         = (count_q == CNT_W'(SLOT_COUNT));
    status_o.id_valid     = id_valid_q;
    status_o.used         = flag_rdata.used;
    status_o.queued       = flag_rdata.queued;
    status_o.is_head      = (id_q == head_q);
    status_o.head_is_tail = (head_q == tail_q);
    status_o.scan_hit     = scan_hit;
    status_o.walk_hit     = (link_rdata == id_q);
    status_o.walk_end     = (link_rdata == tail_q);
    status_o.clear_last   = (clr_ptr_q == ID_W'(SLOT_COUNT - 1));
    status_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{OUT_PAD_W{1'b0}}, out_count_q, out_idle_q, out_run_q,
                        out_assigned_q, out_status_q};

endmodule

// ----- hw/rtl/round_robin_run_queue_unit.sv -----
// Top level of the round-robin run queue unit: slot allocation and FIFO run queue.
//
// The unit keeps a table of SLOT_COUNT task slots, a singly linked FIFO run
// queue threaded through them, and the identity of the running task. Each
// command transfer on the slave stream (command in tuser, task id in tdata)
// yields exactly one result transfer on the master stream. Schedule takes the
// lowest free slot, appends it to the queue tail and returns its id, or
// reports a full table. Unschedule takes a task out of the queue and frees its
// slot. Enqueue appends an occupied slot, and dequeue unlinks a task from
// anywhere in the queue; when the running task leaves, its successor runs, or
// the idle task if it has none. Commands are handled one at a time. Schedule
// scans the slot flag memory one entry per cycle from slot 0 until it finds
// the lowest free slot. Dequeue and unschedule of a queued task read its link
// and, unless it is the queue head, walk the links from the head one entry per
// cycle through the single read port of the link memory until they reach its
// predecessor. A new command is accepted as soon as the previous result sits
// in the output register, even if that result has not been taken yet. After
// reset the unit clears the slot flag memory in one pass over all SLOT_COUNT
// slots, during which s_axis_tready stays low.
module round_robin_run_queue_unit #(
  parameter int SLOT_COUNT = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Command stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rrq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [6:0] task_id, [7] zero
  input  logic [rrq_pkg::CMD_W-1:0]          s_axis_tuser,  // [1:0] command
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [8:2] assigned_id, [15:9] running_id, [16] running_idle,
  // [24:17] task_count, [31:25] zero
  output logic [rrq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import rrq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The controller sequences each command; all storage lives in the datapath.
  rrq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd)
  );

  // The datapath latches the command on the load command, which the
  // controller raises exactly on an accepted command transfer.
  rrq_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (s_axis_tuser),
    .in_task_id_i(s_axis_tdata[TASK_ID_W-1:0]),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench of the round-robin run queue unit.
module testbench;
  import rrq_pkg::*;

  localparam int SLOTS = 128;
  localparam int RANDOM_COMMANDS = 1450;
  localparam int HOLD_CYCLES = 400;

  // One command as it travels on the slave stream.
  typedef struct packed {
    cmd_e                 cmd;
    logic [TASK_ID_W-1:0] id;
  } command_t;

  // One result as it travels on the master stream.
  typedef struct packed {
    status_e                 status;
    logic [TASK_ID_W-1:0]    assigned;
    logic [TASK_ID_W-1:0]    running;
    logic                    idle;
    logic [TASK_COUNT_W-1:0] count;
  } outcome_t;

  // Scheduler state as the testbench tracks it: slot table, run queue, running task.
  typedef struct packed {
    logic [SLOTS-1:0]                used;
    logic [SLOTS-1:0]                queued;
    logic [SLOTS-1:0][TASK_ID_W-1:0] link;
    logic [TASK_ID_W-1:0]            head;
    logic [TASK_ID_W-1:0]            tail;
    logic [TASK_ID_W-1:0]            cur;
    logic                            empty;
    logic                            idle;
    logic [TASK_COUNT_W-1:0]         count;
  } sched_state_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]        s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  command_t     cmd_backlog[$];
  outcome_t     expected_outcomes[$];
  sched_state_t plan_state;   // advanced as commands are planned, steers the stimulus
  sched_state_t model_state;  // advanced as commands are accepted, gives the expectations
  command_t     offered;
  int unsigned  gap_left = 0;
  int unsigned  send_calm = 0;
  int unsigned  stall_left = 0;
  int unsigned  take_calm = 0;
  int unsigned  hold_left = 0;
  int unsigned  next_hold_at = 250;
  int unsigned  results_seen = 0;
  int unsigned  failures = 0;

  round_robin_run_queue_unit #(
    .SLOT_COUNT(SLOTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic sched_state_t cleared_state();
    sched_state_t s;
    s = '0;
    s.empty = 1'b1;
    s.idle  = 1'b1;
    return s;
  endfunction

  // Appends a slot at the queue tail; an idle processor picks it up at once.
  function automatic void queue_append(inout sched_state_t st, input logic [TASK_ID_W-1:0] id);
    if (st.empty) begin
      st.head  = id;
      st.empty = 1'b0;
    end else begin
      st.link[st.tail] = id;
    end
    st.tail = id;
    st.queued[id] = 1'b1;
    if (st.idle) begin
      st.cur  = id;
      st.idle = 1'b0;
    end
  endfunction

  // Unlinks a queued slot; the predecessor is found by walking from the head.
  function automatic void queue_unlink(inout sched_state_t st, input logic [TASK_ID_W-1:0] id);
    logic                 at_tail;
    logic                 found_prev;
    logic [TASK_ID_W-1:0] succ;
    logic [TASK_ID_W-1:0] prev;
    logic [TASK_ID_W-1:0] p;
    at_tail    = (id == st.tail);
    succ       = at_tail ? '0 : st.link[id];
    found_prev = 1'b0;
    prev       = '0;
    if (id == st.head) begin
      if (at_tail) st.empty = 1'b1;
      else st.head = succ;
    end else begin
      p = st.head;
      for (int n = 0; n < SLOTS; n++) begin
        if (p == st.tail) break;
        if (st.link[p] == id) begin
          found_prev = 1'b1;
          prev = p;
          break;
        end
        p = st.link[p];
      end
      if (found_prev && !at_tail) st.link[prev] = succ;
    end
    if (at_tail && found_prev) st.tail = prev;
    st.queued[id] = 1'b0;
    // The running task leaving hands the processor to its successor, or to idle.
    if (!st.idle && st.cur == id) begin
      if (!at_tail) begin
        st.cur = succ;
      end else begin
        st.cur  = '0;
        st.idle = 1'b1;
      end
    end
  endfunction

  // Applies one command to a scheduler state and returns the result it produces.
  function automatic outcome_t apply_command(inout sched_state_t st, input command_t c);
    outcome_t r;
    int       free_slot;
    r.status   = STATUS_OK;
    r.assigned = '0;
    if (c.cmd == CMD_SCHEDULE) begin
      free_slot = -1;
      if (st.count < SLOTS) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!st.used[i]) begin
            free_slot = i;
            break;
          end
        end
      end
      if (free_slot < 0) begin
        r.status = STATUS_FULL;
      end else begin
        st.used[free_slot] = 1'b1;
        st.count = st.count + 1'b1;
        queue_append(st, TASK_ID_W'(free_slot));
        r.assigned = TASK_ID_W'(free_slot);
      end
    end else if (!st.used[c.id]) begin
      r.status = STATUS_FREE;
    end else if (c.cmd == CMD_UNSCHEDULE) begin
      if (st.queued[c.id]) queue_unlink(st, c.id);
      st.used[c.id] = 1'b0;
      if (st.count > 0) st.count = st.count - 1'b1;
    end else if (c.cmd == CMD_ENQUEUE) begin
      if (st.queued[c.id]) r.status = STATUS_MEMBERSHIP;
      else queue_append(st, c.id);
    end else begin
      if (!st.queued[c.id]) r.status = STATUS_MEMBERSHIP;
      else queue_unlink(st, c.id);
    end
    r.running = st.idle ? '0 : st.cur;
    r.idle    = st.idle;
    r.count   = st.count;
    return r;
  endfunction

  function automatic void push_command(cmd_e c, int id);
    command_t item;
    item.cmd = c;
    item.id  = TASK_ID_W'(id);
    cmd_backlog.push_back(item);
    void'(apply_command(plan_state, item));
  endfunction

  // Returns a random set position of the mask, or -1 when it is empty.
  function automatic int pick_slot(logic [SLOTS-1:0] mask);
    int start;
    int k;
    if (mask == '0) return -1;
    start = $urandom_range(0, SLOTS - 1);
    for (k = 0; k < SLOTS; k++) begin
      if (mask[(start + k) % SLOTS]) return (start + k) % SLOTS;
    end
    return -1;
  endfunction

  // Plans one random command, mostly aimed at slots in the right state for it.
  // While draining, unschedule dominates so a full table empties out again.
  function automatic void plan_random(bit draining);
    int r;
    int id;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      push_command(cmd_e'($urandom_range(0, 3)), $urandom_range(0, SLOTS - 1));
    end else if (r < 30 && !draining && plan_state.count < 48) begin
      push_command(CMD_SCHEDULE, $urandom_range(0, SLOTS - 1));
    end else if (r < 45 || (draining && r < 70)) begin
      id = pick_slot(plan_state.used);
      if (id < 0 || r % 8 == 0) id = $urandom_range(0, SLOTS - 1);
      push_command(CMD_UNSCHEDULE, id);
    end else if (r < 72) begin
      id = pick_slot(plan_state.used & ~plan_state.queued);
      if (id < 0 || r % 9 == 0) id = pick_slot(plan_state.queued);
      if (id < 0) id = $urandom_range(0, SLOTS - 1);
      push_command(CMD_ENQUEUE, id);
    end else begin
      if (!plan_state.idle && r < 82) id = plan_state.cur;
      else if (!plan_state.empty && r < 87) id = plan_state.tail;
      else id = pick_slot(plan_state.queued);
      if (id < 0 || r % 10 == 0) id = pick_slot(plan_state.used);
      if (id < 0) id = $urandom_range(0, SLOTS - 1);
      push_command(CMD_DEQUEUE, id);
    end
  endfunction

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: result %0d field %s expected %0d actual %0d",
               $time, results_seen, name, want, got);
      failures++;
    end
  endfunction

  // Command driver: offers the planned commands and records the expected result of
  // each transfer at the edge where it is accepted.
  always @(posedge clk_i) begin : drive_commands
    command_t next_cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_outcomes.push_back(apply_command(model_state, offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          offered       <= next_cmd;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= next_cmd.cmd;
          s_axis_tdata  <= {1'b0, next_cmd.id};
          if (send_calm != 0) begin
            send_calm <= send_calm - 1;
            gap_left  <= 0;
          end else begin
            gap_left <= idle_span();
            if ($urandom_range(0, 63) == 0) send_calm <= $urandom_range(20, 100);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result transfer and paces m_axis_tready.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h",
                   $time, m_axis_tdata);
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", want.status, m_axis_tdata[1:0]);
          check_field("assigned_id", want.assigned, m_axis_tdata[8:2]);
          check_field("running_id", want.running, m_axis_tdata[15:9]);
          check_field("running_idle", want.idle, m_axis_tdata[16]);
          check_field("task_count", want.count, m_axis_tdata[24:17]);
          check_field("padding", 0, m_axis_tdata[31:25]);
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (take_calm != 0) begin
          take_calm <= take_calm - 1;
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left <= idle_span();
          if ($urandom_range(0, 63) == 0) take_calm <= $urandom_range(50, 200);
        end
      end
    end
  end

  // Back-pressure episodes: the receiver stops for a long stretch twice, while the
  // driver keeps offering, so the output register and then the input back up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (results_seen == next_hold_at) begin
        hold_left    <= HOLD_CYCLES;
        next_hold_at <= next_hold_at + 700;
      end
    end
  end

  initial begin
    bit draining;
    plan_state  = cleared_state();
    model_state = cleared_state();
    draining    = 1'b0;

    // Directed part. Operations on free slots, the highest id among them.
    push_command(CMD_UNSCHEDULE, 0);
    push_command(CMD_ENQUEUE, SLOTS - 1);
    push_command(CMD_DEQUEUE, 0);
    push_command(CMD_SCHEDULE, SLOTS - 1);  // first task runs at once
    push_command(CMD_SCHEDULE, 0);
    push_command(CMD_SCHEDULE, 85);
    push_command(CMD_ENQUEUE, 1);           // already queued
    push_command(CMD_DEQUEUE, 1);           // middle of the queue, needs the walk
    push_command(CMD_DEQUEUE, 1);           // no longer queued
    push_command(CMD_UNSCHEDULE, 1);        // unqueued task is simply freed
    push_command(CMD_DEQUEUE, 0);           // running head leaves, successor runs
    push_command(CMD_DEQUEUE, 2);           // running task without successor: idle
    push_command(CMD_ENQUEUE, 0);           // enqueue while idle starts the task
    push_command(CMD_ENQUEUE, 2);
    push_command(CMD_SCHEDULE, 42);         // reuses the lowest free slot
    push_command(CMD_DEQUEUE, 1);           // tail leaves, tail moves back
    push_command(CMD_ENQUEUE, 1);
    push_command(CMD_UNSCHEDULE, 0);        // unschedule of the running head
    push_command(CMD_UNSCHEDULE, 1);        // unschedule of the queued tail
    push_command(CMD_UNSCHEDULE, 2);        // last task leaves, idle again
    push_command(CMD_ENQUEUE, 2);           // freed slot
    push_command(CMD_SCHEDULE, 127);

    // Random part, with two passes that fill the table completely.
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n == 350 || n == 1050) begin
        while (plan_state.count < SLOTS) begin
          push_command(CMD_SCHEDULE, $urandom_range(0, SLOTS - 1));
          n++;
        end
        repeat (3) push_command(CMD_SCHEDULE, $urandom_range(0, SLOTS - 1));
        n += 3;
        draining = 1'b1;
      end
      if (draining && plan_state.count <= 16) draining = 1'b0;
      plan_random(draining);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_ram.sv
hw/rtl/rrq_ctrl.sv
hw/rtl/rrq_dp.sv
hw/rtl/round_robin_run_queue_unit.sv
sim/testbench.sv
